// ===== hw/rtl/ccfm_pkg.sv =====
// Shared constants, codes and types of the commanded channel fault monitor.
`default_nettype none

package ccfm_pkg;

  // Slot geometry
  localparam int SIDES            = 2;
  localparam int BUTTONS_PER_SIDE = 4;
  localparam int NSLOTS           = SIDES * BUTTONS_PER_SIDE;

  // Timeout default: 1000 ms timeout at a 10 ms tick
  localparam int TMO_SPAN_MS      = 1000;
  localparam int TICK_MS          = 10;
  localparam logic [7:0] TIMEOUT_RESET = 8'(TMO_SPAN_MS / TICK_MS);

  // Field widths
  localparam int CHAN_W     = 16;
  localparam int CNT_W      = 8;
  localparam int FX_W       = 32;
  localparam int FLAG_W     = 16;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  localparam int REG_TIMEOUT    = 0;
  localparam int REG_MASK_BASE  = 1;
  localparam int MASKS_PER_WORD = 4;

  // Operation codes
  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_OBSERVE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  // Slot status codes
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_PENDING = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

  // Effect codes
  localparam logic [1:0] FX_DISABLED = 2'd0;
  localparam logic [1:0] FX_ENABLED  = 2'd1;
  localparam logic [1:0] FX_WAIT     = 2'd2;
  localparam logic [1:0] FX_FAULT    = 2'd3;

  // Per-slot stored state
  typedef struct packed {
    logic [CHAN_W-1:0] mask;
    logic [CHAN_W-1:0] value;
    logic [1:0]        status;
    logic [CNT_W-1:0]  count;
  } slot_state_t;

  // Command broadcast from the top level to every slot
  typedef struct packed {
    logic              fire;
    logic [1:0]        op;
    logic [CHAN_W-1:0] press_mask;
    logic [CHAN_W-1:0] press_value;
    logic [CHAN_W-1:0] channels;
    logic [CHAN_W-1:0] relay_target;
    logic [CHAN_W-1:0] observed;
    logic [CNT_W-1:0]  timeout;
  } slot_cmd_t;

  // What one slot shows after the current request
  typedef struct packed {
    logic [1:0] effect;
    logic       err;
    logic       pend;
  } slot_view_t;

endpackage

`default_nettype wire

// ===== hw/rtl/commanded_channel_fault_monitor.sv =====
// Top level of the commanded channel fault monitor.
//
// Usage:
//   Requests arrive on the s_ channel: s_tuser carries the operation (press,
//   observation, tick, clear slot), s_tdata the slot address and data words.
//   Every request gives exactly one result on the m_ channel: the 2-bit
//   effect code of each slot plus error and pending flags, as they stand
//   after that request. Configuration (timeout and slot channel masks) is
//   written through cfg_we/cfg_index/cfg_data while the block is idle.
//   A request passes the input register, then its result the result
//   register. Throughput is one request per cycle while the receiver takes
//   results without stalling; all slots update in parallel from the single
//   input register.
//   When the receiver stalls, the result register holds, the input register
//   holds the next request, and s_tready drops once both are full.
//   Reset (synchronous, active high) empties both registers, sets every
//   slot idle with zero mask and value, clears the last observation and
//   loads the timeout default of 100 ticks and all-zero masks.
`default_nettype none

module commanded_channel_fault_monitor (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // request channel
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // tdata: slot_side, slot_button, press_mask, press_value, channels,
  //        relay_target, zero pad
  input  wire logic [ccfm_pkg::IN_DATA_W-1:0]    s_tdata,
  // tuser: operation
  input  wire logic [1:0]                        s_tuser,
  // result channel
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // tdata: slot_effects, error_flags, pending_flags
  output logic [ccfm_pkg::OUT_DATA_W-1:0]        m_tdata,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [ccfm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ccfm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Input register
  logic                          in_valid;
  logic [1:0]                    in_op;
  logic                          in_side;
  logic [2:0]                    in_button;
  logic [ccfm_pkg::CHAN_W-1:0]   in_pmask;
  logic [ccfm_pkg::CHAN_W-1:0]   in_pvalue;
  logic [ccfm_pkg::CHAN_W-1:0]   in_chans;
  logic [ccfm_pkg::CHAN_W-1:0]   in_target;

  // Configuration and shared state
  logic [ccfm_pkg::CNT_W-1:0]    timeout_ticks;
  logic [ccfm_pkg::CHAN_W-1:0]   cfg_mask [ccfm_pkg::NSLOTS];
  logic [ccfm_pkg::CHAN_W-1:0]   last_observed;

  logic                          advance;
  logic                          fire;
  ccfm_pkg::slot_cmd_t           cmd;
  logic [ccfm_pkg::NSLOTS-1:0]   hit;
  ccfm_pkg::slot_view_t          view [ccfm_pkg::NSLOTS];
  logic [ccfm_pkg::FX_W-1:0]     fx_next;
  logic [ccfm_pkg::FLAG_W-1:0]   err_next;
  logic [ccfm_pkg::FLAG_W-1:0]   pend_next;

  // Handshake: result register free or being taken moves the pipe on
  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op     <= s_tuser;
      in_side   <= s_tdata[0];
      in_button <= s_tdata[3:1];
      in_pmask  <= s_tdata[19:4];
      in_pvalue <= s_tdata[35:20];
      in_chans  <= s_tdata[51:36];
      in_target <= s_tdata[67:52];
    end
  end

  // Configuration registers; mask words past the slot count are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= ccfm_pkg::TIMEOUT_RESET;
      for (int k = 0; k < ccfm_pkg::NSLOTS; k++) begin
        cfg_mask[k] <= '0;
      end
    end else if (cfg_we) begin
      if (int'(cfg_index) == ccfm_pkg::REG_TIMEOUT) begin
        timeout_ticks <= cfg_data[ccfm_pkg::CNT_W-1:0];
      end
      for (int k = 0; k < ccfm_pkg::NSLOTS; k++) begin
        if (int'(cfg_index) == ccfm_pkg::REG_MASK_BASE + k / ccfm_pkg::MASKS_PER_WORD) begin
          cfg_mask[k] <= cfg_data[ccfm_pkg::CHAN_W * (k % ccfm_pkg::MASKS_PER_WORD) +:
                                  ccfm_pkg::CHAN_W];
        end
      end
    end
  end

  // Last observation, used by later presses and re-tracks
  always_ff @(posedge clk) begin
    if (rst) begin
      last_observed <= '0;
    end else if (fire && in_op == ccfm_pkg::OP_OBSERVE) begin
      last_observed <= in_chans;
    end
  end

  // Command to all slots
  always_comb begin
    cmd.fire         = fire;
    cmd.op           = in_op;
    cmd.press_mask   = in_pmask;
    cmd.press_value  = in_pvalue;
    cmd.channels     = in_chans;
    cmd.relay_target = in_target;
    cmd.observed     = last_observed;
    cmd.timeout      = timeout_ticks;
  end

  // Slot array; an out-of-range address matches no slot
  for (genvar k = 0; k < ccfm_pkg::NSLOTS; k++) begin : g_slot
    assign hit[k] = (int'(in_side) == k / ccfm_pkg::BUTTONS_PER_SIDE) &&
                    (int'(in_button) == k % ccfm_pkg::BUTTONS_PER_SIDE);

    ccfm_slot u_slot (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .hit      (hit[k]),
      .cfg_mask (cfg_mask[k]),
      .view     (view[k])
    );
  end

  // Gather the result; bits of absent slots stay zero
  always_comb begin
    fx_next   = '0;
    err_next  = '0;
    pend_next = '0;
    for (int k = 0; k < ccfm_pkg::NSLOTS; k++) begin
      fx_next[2*k +: 2] = view[k].effect;
      err_next[k]       = view[k].err;
      pend_next[k]      = view[k].pend;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {pend_next, err_next, fx_next};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ccfm_slot.sv =====
// One monitor slot: expected mask and value, status and countdown.
`default_nettype none

module ccfm_slot (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ccfm_pkg::slot_cmd_t           cmd,
  input  wire logic                          hit,
  input  wire logic [ccfm_pkg::CHAN_W-1:0]   cfg_mask,
  output ccfm_pkg::slot_view_t               view
);

  ccfm_pkg::slot_state_t st;
  ccfm_pkg::slot_state_t st_next;
  ccfm_pkg::slot_state_t tracked;

  // New or changed expectation: idle if nothing to see or already seen
  function automatic ccfm_pkg::slot_state_t track(
    input ccfm_pkg::slot_state_t           s,
    input logic [ccfm_pkg::CHAN_W-1:0]     m,
    input logic [ccfm_pkg::CHAN_W-1:0]     val,
    input logic [ccfm_pkg::CHAN_W-1:0]     obs,
    input logic [ccfm_pkg::CNT_W-1:0]      tmo
  );
    ccfm_pkg::slot_state_t     r;
    logic [ccfm_pkg::CHAN_W-1:0] v;
    r = s;
    v = val & m;
    if (!(s.mask == m && s.value == v)) begin
      r.mask  = m;
      r.value = v;
      if (v == '0 || (obs & m) == v) begin
        r.status = ccfm_pkg::ST_IDLE;
        r.count  = '0;
      end else begin
        r.status = ccfm_pkg::ST_PENDING;
        r.count  = tmo;
      end
    end
    return r;
  endfunction

  // Tick re-track from relay target and configured mask
  always_comb begin
    tracked = track(st, cfg_mask, cmd.relay_target, cmd.observed, cmd.timeout);
  end

  // Next state for the request in hand
  always_comb begin
    st_next = st;
    case (cmd.op)
      ccfm_pkg::OP_PRESS: begin
        if (hit) begin
          st_next = track(st, cmd.press_mask, cmd.press_value, cmd.observed, cmd.timeout);
        end
      end
      ccfm_pkg::OP_OBSERVE: begin
        if (st.mask != '0) begin
          if ((cmd.channels & st.mask) == st.value) begin
            if (st.status != ccfm_pkg::ST_IDLE) begin
              st_next.status = ccfm_pkg::ST_IDLE;
              st_next.count  = '0;
            end
          end else if (st.status == ccfm_pkg::ST_IDLE && st.value != '0) begin
            // settled slot lost its voltage
            st_next.status = ccfm_pkg::ST_ERROR;
            st_next.count  = '0;
          end
        end
      end
      ccfm_pkg::OP_TICK: begin
        st_next = tracked;
        if (tracked.status == ccfm_pkg::ST_PENDING) begin
          if (tracked.count == '0) begin
            st_next.status = ccfm_pkg::ST_ERROR;
          end else begin
            st_next.count = tracked.count - 1'b1;
          end
        end
      end
      ccfm_pkg::OP_CLEAR: begin
        if (hit) begin
          st_next.mask   = '0;
          st_next.value  = '0;
          st_next.status = ccfm_pkg::ST_IDLE;
          st_next.count  = '0;
        end
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mask   <= '0;
      st.value  <= '0;
      st.status <= ccfm_pkg::ST_IDLE;
      st.count  <= '0;
    end else if (cmd.fire) begin
      st <= st_next;
    end
  end

  // Effect and flags as they stand after this request
  always_comb begin
    view.err  = (st_next.status == ccfm_pkg::ST_ERROR);
    view.pend = (st_next.status == ccfm_pkg::ST_PENDING);
    if (view.err) begin
      view.effect = ccfm_pkg::FX_FAULT;
    end else if (view.pend) begin
      view.effect = ccfm_pkg::FX_WAIT;
    end else if ((st_next.mask & st_next.value) != '0) begin
      view.effect = ccfm_pkg::FX_ENABLED;
    end else begin
      view.effect = ccfm_pkg::FX_DISABLED;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ccfm_checker.sv =====
// Port-level checks of the commanded channel fault monitor and their binding.
`default_nettype none

module ccfm_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [ccfm_pkg::OUT_DATA_W-1:0]   m_tdata
);

  // Effect codes agree with the flags, and absent slots show nothing
  function automatic logic view_ok(input logic [ccfm_pkg::OUT_DATA_W-1:0] d);
    logic ok;
    logic [1:0] code;
    ok = 1'b1;
    for (int k = 0; k < ccfm_pkg::FLAG_W; k++) begin
      code = d[2*k +: 2];
      if (k < ccfm_pkg::NSLOTS) begin
        if (d[ccfm_pkg::FX_W + k] != (code == ccfm_pkg::FX_FAULT)) ok = 1'b0;
        if (d[ccfm_pkg::FX_W + ccfm_pkg::FLAG_W + k] != (code == ccfm_pkg::FX_WAIT)) ok = 1'b0;
      end else begin
        if (code != 2'd0 || d[ccfm_pkg::FX_W + k] || d[ccfm_pkg::FX_W + ccfm_pkg::FLAG_W + k])
          ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // A slot is never both in error and pending
  a_flags_disjoint: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[47:32] & m_tdata[63:48]) == '0)
    else $error("slot both in error and pending");

  a_view_consistent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> view_ok(m_tdata))
    else $error("effect codes disagree with flags");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // An empty result register never blocks new requests
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("request blocked with result register empty");

  // Nothing comes out straight after reset
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind commanded_channel_fault_monitor ccfm_checker u_ccfm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
